### hw/rtl/aluc_pkg.sv
// ----------------------------------------------------------------------------
// aluc_pkg: shared types and constants of the ALU execute stage
// Opcode and fault codes, word layouts of both channels and the entry format
// of the queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

package aluc_pkg;

   localparam int DataWidth     = 32;
   localparam int CountWidth    = $clog2(DataWidth);
   localparam int HalfWidth     = DataWidth / 2;
   localparam int QueueDepth    = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   typedef enum logic [4:0] {
      OPC_SYS  = 5'd0,
      OPC_JMP  = 5'd1,
      OPC_JZ   = 5'd2,
      OPC_JP   = 5'd3,
      OPC_JPB  = 5'd4,
      OPC_JN   = 5'd5,
      OPC_JNZ  = 5'd6,
      OPC_JNP  = 5'd7,
      OPC_JNN  = 5'd8,
      OPC_NOT  = 5'd9,
      OPC_STOP = 5'd15,
      OPC_MOV  = 5'd16,
      OPC_ADD  = 5'd17,
      OPC_SUB  = 5'd18,
      OPC_MUL  = 5'd19,
      OPC_DIV  = 5'd20,
      OPC_CMP  = 5'd21,
      OPC_SHL  = 5'd22,
      OPC_SHR  = 5'd23,
      OPC_SAR  = 5'd24,
      OPC_AND  = 5'd25,
      OPC_OR   = 5'd26,
      OPC_XOR  = 5'd27,
      OPC_SWAP = 5'd28,
      OPC_LDL  = 5'd29,
      OPC_LDH  = 5'd30,
      OPC_RND  = 5'd31
   } opcode_type;

   typedef enum logic [2:0] {
      FAULT_NONE     = 3'd0,
      FAULT_INVALID  = 3'd1,
      FAULT_DIV_ZERO = 3'd2,
      FAULT_HALT     = 3'd3,
      FAULT_SYSCALL  = 3'd4
   } fault_type;

   // execution class chosen by the front
   typedef enum logic [2:0] {
      CLS_FAULT,
      CLS_JUMP,
      CLS_ALU,
      CLS_MUL,
      CLS_DIV
   } exec_class_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_DIV
   } back_state_type;

   typedef struct packed {
      logic [4:0]                  req_type;
      logic signed [DataWidth-1:0] first_value;
      logic signed [DataWidth-1:0] second_value;
   } req_word_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] result_value;
      logic                        write_first;
      logic signed [DataWidth-1:0] swap_value;
      logic                        write_second;
      logic signed [DataWidth-1:0] remainder_value;
      logic                        write_remainder;
      logic                        branch_taken;
      logic                        flag_negative;
      logic                        flag_zero;
      logic [2:0]                  fault_code;
   } rsp_word_type;

   typedef struct packed {
      exec_class_type       cls;
      opcode_type           opcode;
      fault_type            fault;
      logic [DataWidth-1:0] first;
      logic [DataWidth-1:0] second;
   } entry_type;

endpackage

`default_nettype wire

### hw/rtl/aluc_front.sv
// ----------------------------------------------------------------------------
// aluc_front: instruction classifier and queue
// Decodes each accepted word into an execution class, resolves faults that
// need no computation and holds the entries in a short queue for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module aluc_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_push,
   output logic                         req_full,
   input  wire aluc_pkg::req_word_type  req_word,
   output logic                         head_valid,
   output aluc_pkg::entry_type          head,
   input  wire                          head_take
);

   aluc_pkg::entry_type                      queue_ff [aluc_pkg::QueueDepth];
   logic [aluc_pkg::QueuePtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [aluc_pkg::QueuePtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [aluc_pkg::QueueCntWidth-1:0]       count_ff, count_in;
   aluc_pkg::entry_type                      decoded;
   logic                                     push_ok;
   logic                                     pop_ok;

   // classify the incoming word
   always_comb begin
      decoded.opcode = aluc_pkg::opcode_type'(req_word.req_type);
      decoded.first  = req_word.first_value;
      decoded.second = req_word.second_value;
      decoded.cls    = aluc_pkg::CLS_FAULT;
      decoded.fault  = aluc_pkg::FAULT_NONE;
      case (decoded.opcode)
         aluc_pkg::OPC_SYS: begin
            decoded.fault = aluc_pkg::FAULT_SYSCALL;
         end
         aluc_pkg::OPC_STOP: begin
            decoded.fault = aluc_pkg::FAULT_HALT;
         end
         aluc_pkg::OPC_JMP, aluc_pkg::OPC_JZ, aluc_pkg::OPC_JP, aluc_pkg::OPC_JPB,
         aluc_pkg::OPC_JN, aluc_pkg::OPC_JNZ, aluc_pkg::OPC_JNP,
         aluc_pkg::OPC_JNN: begin
            decoded.cls = aluc_pkg::CLS_JUMP;
         end
         aluc_pkg::OPC_MUL: begin
            decoded.cls = aluc_pkg::CLS_MUL;
         end
         aluc_pkg::OPC_DIV: begin
            if (req_word.second_value == '0) begin
               decoded.fault = aluc_pkg::FAULT_DIV_ZERO;
            end else begin
               decoded.cls = aluc_pkg::CLS_DIV;
            end
         end
         aluc_pkg::OPC_NOT, aluc_pkg::OPC_MOV, aluc_pkg::OPC_ADD, aluc_pkg::OPC_SUB,
         aluc_pkg::OPC_CMP, aluc_pkg::OPC_SHL, aluc_pkg::OPC_SHR, aluc_pkg::OPC_SAR,
         aluc_pkg::OPC_AND, aluc_pkg::OPC_OR, aluc_pkg::OPC_XOR, aluc_pkg::OPC_SWAP,
         aluc_pkg::OPC_LDL, aluc_pkg::OPC_LDH: begin
            decoded.cls = aluc_pkg::CLS_ALU;
         end
         default: begin
            decoded.fault = aluc_pkg::FAULT_INVALID;
         end
      endcase
   end

   // queue pointers and fill count
   assign req_full   = (count_ff == aluc_pkg::QueueCntWidth'(aluc_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = head_take && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the classified entry
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/aluc_divider.sv
// ----------------------------------------------------------------------------
// aluc_divider: iterative unsigned divider
// Restoring division of two magnitudes, one quotient bit per cycle; done
// pulses for one cycle once quotient and remainder are final.
// ----------------------------------------------------------------------------
`default_nettype none

module aluc_divider (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire [aluc_pkg::DataWidth-1:0]     dividend,
   input  wire [aluc_pkg::DataWidth-1:0]     divisor,
   output logic                              done,
   output logic [aluc_pkg::DataWidth-1:0]    quotient,
   output logic [aluc_pkg::DataWidth-1:0]    remainder
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [aluc_pkg::CountWidth-1:0]     count_ff, count_in;
   logic [aluc_pkg::DataWidth-1:0]      quo_ff, quo_in;
   logic [aluc_pkg::DataWidth-1:0]      rem_ff, rem_in;
   logic [aluc_pkg::DataWidth-1:0]      div_ff, div_in;
   logic [aluc_pkg::DataWidth:0]        shifted;
   logic [aluc_pkg::DataWidth:0]        trial;

   // one restoring step: shift in next dividend bit, try subtract
   assign shifted = {rem_ff, quo_ff[aluc_pkg::DataWidth-1]};
   assign trial   = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = aluc_pkg::CountWidth'(aluc_pkg::DataWidth - 1);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[aluc_pkg::DataWidth-2:0], ~trial[aluc_pkg::DataWidth]};
         rem_in = trial[aluc_pkg::DataWidth] ? shifted[aluc_pkg::DataWidth-1:0]
                                             : trial[aluc_pkg::DataWidth-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/aluc_back.sv
// ----------------------------------------------------------------------------
// aluc_back: execution unit with condition flags
// Carries out queued entries in order: jumps and simple operations directly,
// multiply via its operand registers, divide via the iterative divider. Keeps the
// N and Z flags and holds the finished result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aluc_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          head_valid,
   input  wire aluc_pkg::entry_type     head,
   output logic                         head_take,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output aluc_pkg::rsp_word_type       rsp_word
);

   localparam int W = aluc_pkg::DataWidth;
   localparam int H = aluc_pkg::HalfWidth;

   aluc_pkg::back_state_type   state_ff, state_in;
   logic                       flag_n_ff, flag_n_in;
   logic                       flag_z_ff, flag_z_in;
   logic [W-1:0]               op_a_ff, op_a_in;
   logic [W-1:0]               op_b_ff, op_b_in;
   logic                       neg_quo_ff, neg_quo_in;
   logic                       neg_rem_ff, neg_rem_in;
   aluc_pkg::rsp_word_type     rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       out_free;
   logic                       out_write;
   aluc_pkg::rsp_word_type     out_word;
   logic                       div_start;
   logic                       div_done;
   logic [W-1:0]               div_quo;
   logic [W-1:0]               div_rem;
   logic [W-1:0]               mag_a;
   logic [W-1:0]               mag_b;
   logic [W-1:0]               product;
   logic                       count_big;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign mag_a     = head.first[W-1] ? -head.first : head.first;
   assign mag_b     = head.second[W-1] ? -head.second : head.second;
   assign product   = op_a_ff * op_b_ff;
   assign count_big = (head.second >= W'(W));

   aluc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aluc_pkg::BACK_IDLE: begin
            if (head_valid && out_free) begin
               if (head.cls == aluc_pkg::CLS_MUL) begin
                  state_in = aluc_pkg::BACK_MUL;
               end else if (head.cls == aluc_pkg::CLS_DIV) begin
                  state_in = aluc_pkg::BACK_DIV;
               end
            end
         end
         aluc_pkg::BACK_MUL: begin
            state_in = aluc_pkg::BACK_IDLE;
         end
         aluc_pkg::BACK_DIV: begin
            if (div_done) begin
               state_in = aluc_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = aluc_pkg::BACK_IDLE;
         end
      endcase
   end

   // execute and build the result word
   always_comb begin
      logic         setf;
      logic [W-1:0] res;
      setf        = 1'b0;
      res         = '0;
      head_take   = 1'b0;
      div_start   = 1'b0;
      out_write   = 1'b0;
      out_word    = '0;
      op_a_in     = op_a_ff;
      op_b_in     = op_b_ff;
      neg_quo_in  = neg_quo_ff;
      neg_rem_in  = neg_rem_ff;
      case (state_ff)
         aluc_pkg::BACK_IDLE: begin
            if (head_valid && out_free) begin
               head_take = 1'b1;
               case (head.cls)
                  aluc_pkg::CLS_FAULT: begin
                     out_write           = 1'b1;
                     out_word.fault_code = head.fault;
                  end
                  aluc_pkg::CLS_JUMP: begin
                     out_write             = 1'b1;
                     out_word.result_value = head.first;
                     case (head.opcode)
                        aluc_pkg::OPC_JMP: out_word.branch_taken = 1'b1;
                        aluc_pkg::OPC_JZ:  out_word.branch_taken = flag_z_ff;
                        aluc_pkg::OPC_JP,
                        aluc_pkg::OPC_JPB: out_word.branch_taken = !flag_n_ff && !flag_z_ff;
                        aluc_pkg::OPC_JN:  out_word.branch_taken = flag_n_ff;
                        aluc_pkg::OPC_JNZ: out_word.branch_taken = !flag_z_ff;
                        aluc_pkg::OPC_JNP: out_word.branch_taken = flag_n_ff || flag_z_ff;
                        aluc_pkg::OPC_JNN: out_word.branch_taken = !flag_n_ff;
                        default:           out_word.branch_taken = 1'b0;
                     endcase
                  end
                  aluc_pkg::CLS_ALU: begin
                     out_write            = 1'b1;
                     out_word.write_first = 1'b1;
                     case (head.opcode)
                        aluc_pkg::OPC_NOT: begin
                           res  = ~head.first;
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_MOV: begin
                           res = head.second;
                        end
                        aluc_pkg::OPC_ADD: begin
                           res  = head.first + head.second;
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_SUB: begin
                           res  = head.first - head.second;
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_CMP: begin
                           res                  = head.first - head.second;
                           setf                 = 1'b1;
                           out_word.write_first = 1'b0;
                        end
                        aluc_pkg::OPC_SHL: begin
                           res  = count_big ? '0
                                : head.first << head.second[aluc_pkg::CountWidth-1:0];
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_SHR: begin
                           res  = count_big ? '0
                                : head.first >> head.second[aluc_pkg::CountWidth-1:0];
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_SAR: begin
                           res  = count_big ? {W{head.first[W-1]}}
                                : W'($signed(head.first) >>>
                                     head.second[aluc_pkg::CountWidth-1:0]);
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_AND: begin
                           res  = head.first & head.second;
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_OR: begin
                           res  = head.first | head.second;
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_XOR: begin
                           res  = head.first ^ head.second;
                           setf = 1'b1;
                        end
                        aluc_pkg::OPC_SWAP: begin
                           res                   = head.second;
                           out_word.swap_value   = head.first;
                           out_word.write_second = 1'b1;
                        end
                        aluc_pkg::OPC_LDL: begin
                           res = {head.first[W-1:H], head.second[H-1:0]};
                        end
                        aluc_pkg::OPC_LDH: begin
                           res = {head.second[H-1:0], head.first[H-1:0]};
                        end
                        default: begin
                           res = '0;
                        end
                     endcase
                     out_word.result_value = res;
                  end
                  aluc_pkg::CLS_MUL: begin
                     op_a_in = head.first;
                     op_b_in = head.second;
                  end
                  aluc_pkg::CLS_DIV: begin
                     div_start  = 1'b1;
                     neg_quo_in = head.first[W-1] ^ head.second[W-1];
                     neg_rem_in = head.first[W-1];
                  end
                  default: begin
                     head_take = 1'b1;
                  end
               endcase
            end
         end
         aluc_pkg::BACK_MUL: begin
            res                   = product;
            setf                  = 1'b1;
            out_write             = 1'b1;
            out_word.write_first  = 1'b1;
            out_word.result_value = res;
         end
         aluc_pkg::BACK_DIV: begin
            if (div_done) begin
               res                      = neg_quo_ff ? -div_quo : div_quo;
               setf                     = 1'b1;
               out_write                = 1'b1;
               out_word.write_first     = 1'b1;
               out_word.write_remainder = 1'b1;
               out_word.result_value    = res;
               out_word.remainder_value = neg_rem_ff ? -div_rem : div_rem;
            end
         end
         default: begin
            out_write = 1'b0;
         end
      endcase

      // update flags from the result when the operation sets them
      flag_n_in = flag_n_ff;
      flag_z_in = flag_z_ff;
      if (setf) begin
         flag_n_in = res[W-1];
         flag_z_in = (res == '0);
      end
      out_word.flag_negative = flag_n_in;
      out_word.flag_zero     = flag_z_in;
   end

   // output register: a new word replaces one that is being popped
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_write) begin
         rsp_in       = out_word;
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aluc_pkg::BACK_IDLE;
         flag_n_ff    <= 1'b0;
         flag_z_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_n_ff    <= flag_n_in;
         flag_z_ff    <= flag_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      neg_quo_ff <= neg_quo_in;
      neg_rem_ff <= neg_rem_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/alu_execute_with_condition_flags.sv
// ----------------------------------------------------------------------------
// alu_execute_with_condition_flags: execute stage with N and Z flags
// Top level joining the classifying front queue and the execution back.
// ----------------------------------------------------------------------------
// Instruction words are pushed into a two-entry queue and come out in order,
// one result word each, on a queue-style result port. Jumps, faults and all
// simple operations are executed straight from the queue head, so with pop held
// high one instruction completes per cycle; MUL goes through the operand
// registers, then the 32x32 multiplier into the output register; DIV goes
// through the one-bit-per-cycle restoring divider. The result word of a simple
// operation passes through its queue entry, then the output register, before
// it appears on the result port.
// Jump decisions use the flags left by all earlier instructions.
`default_nettype none

module alu_execute_with_condition_flags (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_push,
   output logic                         req_full,
   input  wire aluc_pkg::req_word_type  req_word,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output aluc_pkg::rsp_word_type       rsp_word
);

   logic                 head_valid;
   aluc_pkg::entry_type  head;
   logic                 head_take;

   // classify and queue
   aluc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   // execute and hold the result
   aluc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

### sim/alu_execute_with_condition_flags_tb.sv
// ----------------------------------------------------------------------------
// alu_execute_with_condition_flags_tb: self-checking bench for the execute stage
// Instruction words go in through the push/full port and result words come out
// through the empty/pop port. Each accepted word is run through a local model
// of the stage, which tracks its own N and Z flags. Every popped result is
// compared field by field with the oldest predicted word. The sender runs in
// random bursts and the receiver stalls on its own pattern. At least once the
// receiver holds off for a long stretch, and at least once the sender drains.
// ----------------------------------------------------------------------------

module alu_execute_with_condition_flags_tb;

   localparam int          CLOCK_HALF       = 6;
   localparam int          RESET_CYCLES     = 6;
   localparam int          RANDOM_WORDS     = 1150;
   localparam int          PRESSURE_WORDS   = 60;
   localparam int          LONG_HOLD        = 300;
   localparam int          DRAIN_CYCLES     = 50;
   localparam int          RUN_LIMIT_CYCLES = 500000;
   localparam logic [4:0]  FIRST_UNUSED_OPC = 5'd10;
   localparam logic [4:0]  LAST_UNUSED_OPC  = 5'd14;

   typedef enum {POP_STREAM, POP_RANDOM, POP_SPARSE} pop_mode_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   aluc_pkg::req_word_type req_word  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   aluc_pkg::rsp_word_type rsp_word;

   // model state: condition flags as seen after every accepted word
   logic                   model_neg = 1'b0;
   logic                   model_zero = 1'b0;
   aluc_pkg::rsp_word_type results_due[$];

   int           mismatches      = 0;
   int           words_sent      = 0;
   int           results_checked = 0;
   int           divides_done    = 0;
   int           branches_taken  = 0;
   int           faults_raised   = 0;

   // sender pacing and receiver hold requests
   bit           sender_paced  = 1'b1;
   int           burst_left    = 0;
   int           hold_requests = 0;

   alu_execute_with_condition_flags DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #(2 * CLOCK_HALF * RUN_LIMIT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

   // compute the result word of one instruction and advance the flags
   function automatic aluc_pkg::rsp_word_type execute_word(input aluc_pkg::req_word_type w);
      aluc_pkg::rsp_word_type r;
      logic [31:0]  a;
      logic [31:0]  b;
      logic [31:0]  mag_a;
      logic [31:0]  mag_b;
      logic [31:0]  quot;
      logic [31:0]  rmd;
      logic         set_flags;
      r         = '0;
      a         = w.first_value;
      b         = w.second_value;
      set_flags = 1'b0;
      case (w.req_type)
         aluc_pkg::OPC_SYS:  r.fault_code = aluc_pkg::FAULT_SYSCALL;
         aluc_pkg::OPC_STOP: r.fault_code = aluc_pkg::FAULT_HALT;
         aluc_pkg::OPC_JMP: begin
            r.result_value = a;
            r.branch_taken = 1'b1;
         end
         aluc_pkg::OPC_JZ: begin
            r.result_value = a;
            r.branch_taken = model_zero;
         end
         aluc_pkg::OPC_JP, aluc_pkg::OPC_JPB: begin
            r.result_value = a;
            r.branch_taken = !model_neg && !model_zero;
         end
         aluc_pkg::OPC_JN: begin
            r.result_value = a;
            r.branch_taken = model_neg;
         end
         aluc_pkg::OPC_JNZ: begin
            r.result_value = a;
            r.branch_taken = !model_zero;
         end
         aluc_pkg::OPC_JNP: begin
            r.result_value = a;
            r.branch_taken = model_neg || model_zero;
         end
         aluc_pkg::OPC_JNN: begin
            r.result_value = a;
            r.branch_taken = !model_neg;
         end
         aluc_pkg::OPC_NOT: begin
            r.result_value = ~a;
            r.write_first  = 1'b1;
            set_flags      = 1'b1;
         end
         aluc_pkg::OPC_MOV: begin
            r.result_value = b;
            r.write_first  = 1'b1;
         end
         aluc_pkg::OPC_ADD, aluc_pkg::OPC_SUB, aluc_pkg::OPC_MUL, aluc_pkg::OPC_AND,
         aluc_pkg::OPC_OR, aluc_pkg::OPC_XOR: begin
            case (w.req_type)
               aluc_pkg::OPC_ADD: r.result_value = a + b;
               aluc_pkg::OPC_SUB: r.result_value = a - b;
               aluc_pkg::OPC_MUL: r.result_value = a * b;
               aluc_pkg::OPC_AND: r.result_value = a & b;
               aluc_pkg::OPC_OR:  r.result_value = a | b;
               default:           r.result_value = a ^ b;
            endcase
            r.write_first = 1'b1;
            set_flags     = 1'b1;
         end
         aluc_pkg::OPC_DIV: begin
            if (b == '0) begin
               r.fault_code = aluc_pkg::FAULT_DIV_ZERO;
            end else begin
               // divide magnitudes, then restore signs (truncate toward zero)
               mag_a = a[31] ? -a : a;
               mag_b = b[31] ? -b : b;
               quot  = mag_a / mag_b;
               rmd   = mag_a % mag_b;
               r.result_value    = (a[31] ^ b[31]) ? -quot : quot;
               r.remainder_value = a[31] ? -rmd : rmd;
               r.write_first     = 1'b1;
               r.write_remainder = 1'b1;
               set_flags         = 1'b1;
            end
         end
         aluc_pkg::OPC_CMP: begin
            r.result_value = a - b;
            set_flags      = 1'b1;
         end
         aluc_pkg::OPC_SHL, aluc_pkg::OPC_SHR, aluc_pkg::OPC_SAR: begin
            // counts of 32 or more saturate
            if (b >= 32) begin
               r.result_value = (w.req_type == aluc_pkg::OPC_SAR) ? {32{a[31]}} : '0;
            end else if (w.req_type == aluc_pkg::OPC_SHL) begin
               r.result_value = a << b[4:0];
            end else if (w.req_type == aluc_pkg::OPC_SHR) begin
               r.result_value = a >> b[4:0];
            end else begin
               r.result_value = $signed(a) >>> b[4:0];
            end
            r.write_first = 1'b1;
            set_flags     = 1'b1;
         end
         aluc_pkg::OPC_SWAP: begin
            r.result_value = b;
            r.swap_value   = a;
            r.write_first  = 1'b1;
            r.write_second = 1'b1;
         end
         aluc_pkg::OPC_LDL: begin
            r.result_value = {a[31:16], b[15:0]};
            r.write_first  = 1'b1;
         end
         aluc_pkg::OPC_LDH: begin
            r.result_value = {b[15:0], a[15:0]};
            r.write_first  = 1'b1;
         end
         default: r.fault_code = aluc_pkg::FAULT_INVALID;
      endcase
      if (set_flags) begin
         model_neg  = r.result_value[31];
         model_zero = (r.result_value == '0);
      end
      r.flag_negative = model_neg;
      r.flag_zero     = model_zero;
      return r;
   endfunction

   // operand mix weighted towards the corners
   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         5:       return $urandom_range(0, 15);
         6:       return -$urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   // second operand suited to the opcode: shift counts and divisors
   function automatic logic [31:0] rand_second(input logic [4:0] opc);
      if (opc == aluc_pkg::OPC_SHL || opc == aluc_pkg::OPC_SHR ||
          opc == aluc_pkg::OPC_SAR) begin
         case ($urandom_range(0, 7))
            0:       return 32'd32;
            1:       return 32'd31;
            2:       return $urandom;
            default: return $urandom_range(0, 40);
         endcase
      end
      if (opc == aluc_pkg::OPC_DIV) begin
         case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return rand_operand();
         endcase
      end
      return rand_operand();
   endfunction

   function automatic logic [4:0] rand_opcode();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)  return 5'($urandom_range(FIRST_UNUSED_OPC, LAST_UNUSED_OPC));
      if (pick < 6)  return aluc_pkg::OPC_RND;
      if (pick < 8)  return aluc_pkg::OPC_SYS;
      if (pick < 10) return aluc_pkg::OPC_STOP;
      if (pick < 30) return 5'($urandom_range(aluc_pkg::OPC_JMP, aluc_pkg::OPC_JNN));
      if (pick < 34) return aluc_pkg::OPC_NOT;
      return 5'($urandom_range(aluc_pkg::OPC_MOV, aluc_pkg::OPC_LDH));
   endfunction

   function automatic logic [4:0] flag_setting_op();
      case ($urandom_range(0, 3))
         0:       return aluc_pkg::OPC_CMP;
         1:       return aluc_pkg::OPC_SUB;
         2:       return aluc_pkg::OPC_ADD;
         default: return aluc_pkg::OPC_AND;
      endcase
   endfunction

   // offer one word, wait for it to be taken and queue its prediction
   task automatic send_word(input aluc_pkg::req_word_type w);
      aluc_pkg::rsp_word_type predicted;
      int                     gap;
      if (sender_paced && burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      req_word <= w;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      predicted = execute_word(w);
      results_due.push_back(predicted);
      words_sent++;
      if (predicted.write_remainder) divides_done++;
      if (predicted.branch_taken) branches_taken++;
      if (predicted.fault_code != aluc_pkg::FAULT_NONE) faults_raised++;
   endtask

   task automatic send_op(input logic [4:0] opc, input logic [31:0] a, input logic [31:0] b);
      aluc_pkg::req_word_type w;
      w.req_type     = opc;
      w.first_value  = a;
      w.second_value = b;
      send_word(w);
   endtask

   task automatic send_random();
      logic [4:0] opc;
      opc = rand_opcode();
      send_op(opc, rand_operand(), rand_second(opc));
   endtask

   // stop offering and wait for every predicted word to come back
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // every opcode but AND and OR at least once, with the wrap and saturation corners
   task automatic test_directed_ops();
      send_op(aluc_pkg::OPC_SYS, 32'h1234_5678, 32'h0000_0000);
      send_op(aluc_pkg::OPC_STOP, 32'h0000_0000, 32'h0000_0000);
      send_op(FIRST_UNUSED_OPC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(LAST_UNUSED_OPC, 32'h0000_0001, 32'h0000_0002);
      send_op(aluc_pkg::OPC_RND, 32'h0000_0003, 32'h0000_0004);
      send_op(aluc_pkg::OPC_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
      send_op(aluc_pkg::OPC_JN, 32'h0000_0100, 32'h0000_0000);
      send_op(aluc_pkg::OPC_JNN, 32'h0000_0200, 32'h0000_0000);
      send_op(aluc_pkg::OPC_SUB, 32'h0000_0005, 32'h0000_0005);
      send_op(aluc_pkg::OPC_JZ, 32'h0000_0300, 32'h0000_0000);
      send_op(aluc_pkg::OPC_JNP, 32'h0000_0400, 32'h0000_0000);
      send_op(aluc_pkg::OPC_MUL, 32'h0001_0000, 32'h0001_0000);
      send_op(aluc_pkg::OPC_DIV, 32'hFFFF_FFF9, 32'h0000_0002);
      send_op(aluc_pkg::OPC_DIV, 32'h0000_0001, 32'h0000_0000);
      send_op(aluc_pkg::OPC_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_op(aluc_pkg::OPC_CMP, 32'h0000_0009, 32'h0000_0004);
      send_op(aluc_pkg::OPC_JP, 32'h0000_0500, 32'h0000_0000);
      send_op(aluc_pkg::OPC_JPB, 32'h0000_0600, 32'h0000_0000);
      send_op(aluc_pkg::OPC_SHL, 32'h0000_0001, 32'd32);
      send_op(aluc_pkg::OPC_SHR, 32'h8000_0000, 32'd31);
      send_op(aluc_pkg::OPC_SAR, 32'h8000_0000, 32'hFFFF_FFFF);
      send_op(aluc_pkg::OPC_NOT, 32'h0000_0000, 32'h0000_0000);
      send_op(aluc_pkg::OPC_JNZ, 32'h0000_0700, 32'h0000_0000);
      send_op(aluc_pkg::OPC_XOR, 32'hFFFF_FFFF, 32'h5555_AAAA);
      send_op(aluc_pkg::OPC_MOV, 32'h0000_0000, 32'h8000_0000);
      send_op(aluc_pkg::OPC_SWAP, 32'h7FFF_FFFF, 32'h8000_0000);
      send_op(aluc_pkg::OPC_LDL, 32'hFFFF_FFFF, 32'h1234_ABCD);
      send_op(aluc_pkg::OPC_LDH, 32'hFFFF_FFFF, 32'h1234_ABCD);
      send_op(aluc_pkg::OPC_JMP, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // flag-setting words followed by jumps, mixed with random words
   task automatic test_random_mix();
      int          target;
      logic [31:0] a;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         if ($urandom_range(0, 3) == 0) begin
            a = rand_operand();
            send_op(flag_setting_op(), a, ($urandom_range(0, 2) == 0) ? a : rand_operand());
            repeat ($urandom_range(1, 3)) begin
               send_op(5'($urandom_range(aluc_pkg::OPC_JMP, aluc_pkg::OPC_JNN)),
                       rand_operand(), rand_operand());
            end
         end else begin
            send_random();
         end
      end
   endtask

   // long receiver hold while the sender keeps offering words back to back
   task automatic test_backpressure();
      sender_paced = 1'b0;
      hold_requests <= hold_requests + 1;
      repeat (PRESSURE_WORDS) send_random();
      sender_paced = 1'b1;
   endtask

   // short groups of words, each drained completely before the next
   task automatic test_drain_pause();
      repeat (6) begin
         repeat ($urandom_range(3, 12)) send_random();
         wait_for_results();
      end
   endtask

   // receiver: long holds on request, otherwise changing stall patterns
   int           holds_served = 0;
   int           hold_left    = 0;
   int           mode_left    = 0;
   pop_mode_type pop_mode     = POP_STREAM;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            pop_mode  = pop_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         case (pop_mode)
            POP_STREAM: rsp_pop <= 1'b1;
            POP_RANDOM: rsp_pop <= $urandom_range(0, 1);
            default:    rsp_pop <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp,
                              input logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, exp, act);
         mismatches++;
      end
   endtask

   // compare each popped word with the oldest prediction
   always @(posedge clock) begin
      aluc_pkg::rsp_word_type exp;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (results_due.size() == 0) begin
            $error("result word popped with no prediction waiting");
            mismatches++;
         end else begin
            exp = results_due.pop_front();
            results_checked++;
            check_field("result_value", exp.result_value, rsp_word.result_value);
            check_field("write_first", exp.write_first, rsp_word.write_first);
            check_field("swap_value", exp.swap_value, rsp_word.swap_value);
            check_field("write_second", exp.write_second, rsp_word.write_second);
            check_field("remainder_value", exp.remainder_value,
                        rsp_word.remainder_value);
            check_field("write_remainder", exp.write_remainder,
                        rsp_word.write_remainder);
            check_field("branch_taken", exp.branch_taken, rsp_word.branch_taken);
            check_field("flag_negative", exp.flag_negative, rsp_word.flag_negative);
            check_field("flag_zero", exp.flag_zero, rsp_word.flag_zero);
            check_field("fault_code", exp.fault_code, rsp_word.fault_code);
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      wait_for_results();
      test_random_mix();
      test_backpressure();
      test_drain_pause();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d instruction words and checked %0d result words.",
               words_sent, results_checked);
      $display("Covered %0d divides, %0d taken branches and %0d faults.",
               divides_done, branches_taken, faults_raised);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
